@@ sv/min_max_normalize_colormap_defines.svh @@
`ifndef MIN_MAX_NORMALIZE_COLORMAP_DEFINES_SVH
`define MIN_MAX_NORMALIZE_COLORMAP_DEFINES_SVH

// same-cycle implication
`define MMNC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MMNC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/mmnc_pkg.sv @@
package mmnc_pkg;

   localparam int SampleW = 32;
   localparam int DiffW   = SampleW + 1;
   localparam int RemW    = DiffW + 1;
   localparam int LevelW  = 8;
   localparam int PixelW  = 32;
   localparam int ModeW   = 2;

   localparam int QDepth  = 2;
   localparam int QIdxW   = (QDepth > 1) ? $clog2(QDepth) : 1;
   localparam int QCntW   = $clog2(QDepth + 1);

   localparam int StepCount = LevelW;
   localparam int StepW     = $clog2(StepCount);

   localparam logic [ModeW-1:0] ModeBw    = 2'd0;
   localparam logic [ModeW-1:0] ModeGrey  = 2'd1;
   localparam logic [ModeW-1:0] ModeRgb   = 2'd2;
   localparam logic [ModeW-1:0] ModeReset = ModeGrey;

   localparam logic OpScan = 1'b0;
   localparam logic OpMap  = 1'b1;

   localparam logic signed [SampleW-1:0] SpanMinReset = 32'sh7FFF_FFFF;
   localparam logic signed [SampleW-1:0] SpanMaxReset = 32'sh8000_0000;

   localparam logic [LevelW-1:0] LevelFull = 8'hFF;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_RUN,
      BACK_DONE
   } back_state_type;

   typedef struct packed {
      logic [ModeW-1:0]        mode;
      logic signed [DiffW-1:0] red_x;
      logic signed [DiffW-1:0] green_x;
      logic signed [DiffW-1:0] span;
   } job_type;

   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } back_ctl_type;

endpackage

@@ sv/min_max_normalize_colormap.sv @@
// Min/max normalization of signed 32-bit samples to 32-bit pixels. Scan items (op 0) fold
// the sample into the running min/max (first=1 restarts it) and give no result. Map items
// (op 1) snapshot the current span and mode into a two-entry queue and give one pixel each;
// the mapping unit runs two 8-step restoring dividers (red and green) in parallel, so each
// map item occupies it through dequeue, 8 quotient steps and the result load, which waits
// while an earlier result is held. Scans keep flowing while the queue has room. Write
// csr_colormap_mode only while no map item is outstanding; it reads 1 (grey) after reset.
module min_max_normalize_colormap (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic                                req_first,
   input  logic signed [mmnc_pkg::SampleW-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mmnc_pkg::PixelW-1:0]         rsp_pixel,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mmnc_pkg::ModeW-1:0]          csr_colormap_mode
);

   mmnc_pkg::job_type push_job, pop_job;
   logic              q_full, q_empty, q_push, q_pop;

   assign csr_ready = 1'b1;

   mmnc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_first         (req_first),
      .req_sample        (req_sample),
      .csr_valid         (csr_valid),
      .csr_colormap_mode (csr_colormap_mode),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_job             (push_job)
   );

   mmnc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .pop_job  (pop_job)
   );

   mmnc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_job     (pop_job),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_pixel (rsp_pixel)
   );

endmodule

@@ sv/mmnc_front.sv @@
module mmnc_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic                                 req_first,
   input  logic signed [mmnc_pkg::SampleW-1:0]  req_sample,
   input  logic                                 csr_valid,
   input  logic [mmnc_pkg::ModeW-1:0]           csr_colormap_mode,
   input  logic                                 q_full,
   output logic                                 q_push,
   output mmnc_pkg::job_type                    q_job
);

   logic [mmnc_pkg::ModeW-1:0]          mode_ff, mode_in;
   logic signed [mmnc_pkg::SampleW-1:0] span_min_ff, span_min_in;
   logic signed [mmnc_pkg::SampleW-1:0] span_max_ff, span_max_in;
   logic                                scan_acc;
   logic signed [mmnc_pkg::DiffW-1:0]   v_x, min_x, max_x;

   assign req_ready = !q_full;
   assign scan_acc  = req_valid && req_ready && (req_op == mmnc_pkg::OpScan);
   assign q_push    = req_valid && req_ready && (req_op == mmnc_pkg::OpMap);

   assign v_x   = {req_sample[mmnc_pkg::SampleW-1], req_sample};
   assign min_x = {span_min_ff[mmnc_pkg::SampleW-1], span_min_ff};
   assign max_x = {span_max_ff[mmnc_pkg::SampleW-1], span_max_ff};

   always_comb begin
      q_job.mode    = mode_ff;
      q_job.red_x   = v_x - min_x;
      q_job.green_x = max_x - v_x;
      q_job.span    = max_x - min_x;
   end

   always_comb begin
      mode_in     = csr_valid ? csr_colormap_mode : mode_ff;
      span_min_in = span_min_ff;
      span_max_in = span_max_ff;
      if (scan_acc) begin
         if (req_first) begin
            span_min_in = req_sample;
            span_max_in = req_sample;
         end else begin
            if (req_sample > span_max_ff) span_max_in = req_sample;
            if (req_sample < span_min_ff) span_min_in = req_sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= mmnc_pkg::ModeReset;
         span_min_ff <= mmnc_pkg::SpanMinReset;
         span_max_ff <= mmnc_pkg::SpanMaxReset;
      end else begin
         mode_ff     <= mode_in;
         span_min_ff <= span_min_in;
         span_max_ff <= span_max_in;
      end
   end

endmodule

@@ sv/mmnc_queue.sv @@
module mmnc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mmnc_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output mmnc_pkg::job_type pop_job
);

   mmnc_pkg::job_type                mem_ff [mmnc_pkg::QDepth];
   logic [mmnc_pkg::QIdxW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [mmnc_pkg::QIdxW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [mmnc_pkg::QCntW-1:0]       count_ff, count_in;

   localparam logic [mmnc_pkg::QIdxW-1:0] LastIdx = mmnc_pkg::QIdxW'(mmnc_pkg::QDepth - 1);
   localparam logic [mmnc_pkg::QCntW-1:0] FullCnt = mmnc_pkg::QCntW'(mmnc_pkg::QDepth);

   assign full    = (count_ff == FullCnt);
   assign empty   = (count_ff == '0);
   assign pop_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LastIdx) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LastIdx) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ sv/mmnc_back.sv @@
module mmnc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  mmnc_pkg::job_type             q_job,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mmnc_pkg::PixelW-1:0]   rsp_pixel
);

   localparam int Lanes = 2;
   localparam logic [mmnc_pkg::StepW-1:0] LastStep = mmnc_pkg::StepW'(mmnc_pkg::StepCount - 1);

   mmnc_pkg::back_state_type state_ff, state_in;
   mmnc_pkg::back_ctl_type   ctl;

   logic [mmnc_pkg::StepW-1:0]        step_ff, step_in;
   logic [mmnc_pkg::ModeW-1:0]        mode_ff;
   logic signed [mmnc_pkg::DiffW-1:0] span_ff;
   logic                              bw_ff;
   logic [mmnc_pkg::LevelW-1:0]       level  [Lanes];
   logic signed [mmnc_pkg::DiffW-1:0] lane_x [Lanes];
   logic signed [mmnc_pkg::DiffW-1:0] half_span;
   logic [mmnc_pkg::RemW-1:0]         div_rem;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [mmnc_pkg::PixelW-1:0]       rsp_pixel_ff, pixel_in;

   assign lane_x[0] = q_job.red_x;
   assign lane_x[1] = q_job.green_x;
   // span/2 truncated toward zero
   assign half_span = (q_job.span +
                       $signed(mmnc_pkg::DiffW'(q_job.span[mmnc_pkg::DiffW-1]))) >>> 1;
   assign div_rem   = {1'b0, span_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mmnc_pkg::BACK_IDLE: if (!q_empty) state_in = mmnc_pkg::BACK_RUN;
         mmnc_pkg::BACK_RUN:  if (step_ff == LastStep) state_in = mmnc_pkg::BACK_DONE;
         mmnc_pkg::BACK_DONE: if (!rsp_valid_ff || rsp_ready) state_in = mmnc_pkg::BACK_IDLE;
         default:             state_in = mmnc_pkg::BACK_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      unique case (state_ff)
         mmnc_pkg::BACK_IDLE: ctl.load = !q_empty;
         mmnc_pkg::BACK_RUN:  ctl.step = 1'b1;
         mmnc_pkg::BACK_DONE: ctl.emit = !rsp_valid_ff || rsp_ready;
         default:             ctl = '0;
      endcase
   end

   assign q_pop   = ctl.load;
   assign step_in = ctl.load ? '0 : (ctl.step ? step_ff + 1'b1 : step_ff);

   for (genvar i = 0; i < Lanes; i++) begin : g_lane
      logic [mmnc_pkg::RemW-1:0]   rem_ff;
      logic [mmnc_pkg::LevelW-1:0] quo_ff;
      logic                        sat_ff;
      logic                        zero_ff;
      logic [mmnc_pkg::RemW-1:0]   shifted;
      assign shifted  = {rem_ff[mmnc_pkg::RemW-2:0], 1'b0};
      assign level[i] = sat_ff ? mmnc_pkg::LevelFull : (zero_ff ? '0 : quo_ff);

      always_ff @(posedge clock) begin
         if (ctl.load) begin
            rem_ff  <= {lane_x[i][mmnc_pkg::DiffW-1], lane_x[i]};
            quo_ff  <= '0;
            sat_ff  <= (lane_x[i] >= q_job.span);
            zero_ff <= (lane_x[i] < 0);
         end else if (ctl.step) begin
            if (shifted >= div_rem) begin
               rem_ff <= shifted - div_rem;
               quo_ff <= {quo_ff[mmnc_pkg::LevelW-2:0], 1'b1};
            end else begin
               rem_ff <= shifted;
               quo_ff <= {quo_ff[mmnc_pkg::LevelW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         mode_ff <= q_job.mode;
         span_ff <= q_job.span;
         bw_ff   <= (q_job.red_x > half_span);
      end
   end

   always_comb begin
      unique case (mode_ff)
         mmnc_pkg::ModeBw:   pixel_in = {24'd0, bw_ff ? mmnc_pkg::LevelFull : 8'd0};
         mmnc_pkg::ModeGrey: pixel_in = {24'd0, level[0]};
         mmnc_pkg::ModeRgb:  pixel_in = {mmnc_pkg::LevelFull, mmnc_pkg::LevelFull,
                                         level[1], level[0]};
         default:            pixel_in = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.emit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) rsp_pixel_ff <= pixel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mmnc_pkg::BACK_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_pixel_ff;

endmodule

@@ sv/mmnc_checker.sv @@
`include "min_max_normalize_colormap_defines.svh"

module mmnc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [mmnc_pkg::PixelW-1:0] rsp_pixel
);

   `MMNC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pixel), "result item dropped or changed while stalled")
   `MMNC_ASSERT_NOW(a_pixel_top, rsp_valid, rsp_pixel[31:16] == 16'h0000 || rsp_pixel[31:16] == 16'hFFFF, "pixel alpha/blue bytes malformed")
   `MMNC_ASSERT_NOW(a_grey_form, rsp_valid && rsp_pixel[31:16] == 16'h0000, rsp_pixel[15:8] == 8'h00, "grey pixel has nonzero upper bytes")

endmodule

bind min_max_normalize_colormap mmnc_checker u_mmnc_checker (.*);

@@ tb/sv/tb_min_max_normalize_colormap.sv @@
module tb_min_max_normalize_colormap;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [mmnc_pkg::ModeW-1:0] ModeUnused = 2'd3;
   localparam int unsigned RandomItems = 1750;
   localparam int unsigned DrainCycles = 16;

   localparam logic signed [mmnc_pkg::SampleW-1:0] SampleMin = 32'sh8000_0000;
   localparam logic signed [mmnc_pkg::SampleW-1:0] SampleMax = 32'sh7FFF_FFFF;

   typedef enum logic [1:0] {ROW_CFG, ROW_SCAN, ROW_MAP} row_kind_type;

   typedef struct packed {
      row_kind_type                        kind;
      logic                                first;
      logic signed [mmnc_pkg::SampleW-1:0] sample;
      logic [mmnc_pkg::ModeW-1:0]          mode;
      logic                                pinned;
      logic [mmnc_pkg::PixelW-1:0]         pixel;
   } row_type;

   localparam int unsigned RowCount = 26;

   row_type directed_rows [0:RowCount-1] = '{
      '{ROW_MAP,  1'b1, SampleMin,    mmnc_pkg::ModeGrey, 1'b1, 32'h0000_00FF},
      '{ROW_MAP,  1'b0, SampleMax,    mmnc_pkg::ModeGrey, 1'b1, 32'h0000_00FF},
      '{ROW_CFG,  1'b0, 32'sd0,       mmnc_pkg::ModeBw,   1'b0, 32'h0},
      '{ROW_MAP,  1'b0, SampleMin,    mmnc_pkg::ModeBw,   1'b0, 32'h0},
      '{ROW_MAP,  1'b0, 32'sd7,       mmnc_pkg::ModeBw,   1'b0, 32'h0},
      '{ROW_SCAN, 1'b1, 32'sd100,     mmnc_pkg::ModeBw,   1'b0, 32'h0},
      '{ROW_MAP,  1'b0, 32'sd100,     mmnc_pkg::ModeBw,   1'b1, 32'h0000_0000},
      '{ROW_CFG,  1'b0, 32'sd0,       mmnc_pkg::ModeGrey, 1'b0, 32'h0},
      '{ROW_MAP,  1'b0, 32'sd100,     mmnc_pkg::ModeGrey, 1'b1, 32'h0000_00FF},
      '{ROW_MAP,  1'b0, 32'sd99,      mmnc_pkg::ModeGrey, 1'b1, 32'h0000_0000},
      '{ROW_SCAN, 1'b0, SampleMin,    mmnc_pkg::ModeGrey, 1'b0, 32'h0},
      '{ROW_SCAN, 1'b0, SampleMax,    mmnc_pkg::ModeGrey, 1'b0, 32'h0},
      '{ROW_MAP,  1'b0, SampleMin,    mmnc_pkg::ModeGrey, 1'b1, 32'h0000_0000},
      '{ROW_MAP,  1'b1, SampleMax,    mmnc_pkg::ModeGrey, 1'b1, 32'h0000_00FF},
      '{ROW_MAP,  1'b0, 32'sd0,       mmnc_pkg::ModeGrey, 1'b0, 32'h0},
      '{ROW_MAP,  1'b0, -32'sd1,      mmnc_pkg::ModeGrey, 1'b0, 32'h0},
      '{ROW_CFG,  1'b0, 32'sd0,       mmnc_pkg::ModeRgb,  1'b0, 32'h0},
      '{ROW_MAP,  1'b0, SampleMin,    mmnc_pkg::ModeRgb,  1'b1, 32'hFFFF_FF00},
      '{ROW_MAP,  1'b0, SampleMax,    mmnc_pkg::ModeRgb,  1'b1, 32'hFFFF_00FF},
      '{ROW_MAP,  1'b0, 32'sd12345,   mmnc_pkg::ModeRgb,  1'b0, 32'h0},
      '{ROW_CFG,  1'b0, 32'sd0,       ModeUnused,         1'b0, 32'h0},
      '{ROW_MAP,  1'b0, 32'sd5,       ModeUnused,         1'b1, 32'h0000_0000},
      '{ROW_SCAN, 1'b1, -32'sd50,     ModeUnused,         1'b0, 32'h0},
      '{ROW_SCAN, 1'b0, 32'sd50,      ModeUnused,         1'b0, 32'h0},
      '{ROW_CFG,  1'b0, 32'sd0,       mmnc_pkg::ModeBw,   1'b0, 32'h0},
      '{ROW_MAP,  1'b0, 32'sd0,       mmnc_pkg::ModeBw,   1'b0, 32'h0}
   };

   logic [mmnc_pkg::ModeW-1:0] mode_pool [0:3] =
      '{mmnc_pkg::ModeBw, mmnc_pkg::ModeGrey, mmnc_pkg::ModeRgb, ModeUnused};

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic                                req_op = mmnc_pkg::OpScan;
   logic                                req_first = 1'b0;
   logic signed [mmnc_pkg::SampleW-1:0] req_sample = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [mmnc_pkg::PixelW-1:0]         rsp_pixel;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [mmnc_pkg::ModeW-1:0]          csr_colormap_mode = mmnc_pkg::ModeGrey;

   // typed-in expectation travels with the item it belongs to
   logic                                pin_valid = 1'b0;
   logic [mmnc_pkg::PixelW-1:0]         pin_pixel = '0;

   logic signed [mmnc_pkg::SampleW-1:0] span_lo;
   logic signed [mmnc_pkg::SampleW-1:0] span_hi;
   logic [mmnc_pkg::ModeW-1:0]          mode_shadow;
   logic [mmnc_pkg::PixelW-1:0]         pixel_queue [$];
   int unsigned                         error_count = 0;
   logic                                burst = 1'b0;
   int unsigned                         stall_left = 0;
   logic                                steady = 1'b0;
   int unsigned                         steady_timer = 0;

   min_max_normalize_colormap DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_first         (req_first),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel         (rsp_pixel),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_colormap_mode (csr_colormap_mode)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [mmnc_pkg::LevelW-1:0] norm_level(input longint x,
                                                               input longint s);
      if (x >= s) return mmnc_pkg::LevelFull;
      if (x < 0) return '0;
      return mmnc_pkg::LevelW'((x * 256) / s);
   endfunction

   function automatic logic [mmnc_pkg::PixelW-1:0] map_pixel(
      input logic signed [mmnc_pkg::SampleW-1:0] v);
      longint d;
      longint s;
      longint g;
      d = longint'(v) - longint'(span_lo);
      s = longint'(span_hi) - longint'(span_lo);
      g = longint'(span_hi) - longint'(v);
      case (mode_shadow)
         mmnc_pkg::ModeBw:
            return (d > s / 2) ? mmnc_pkg::PixelW'(mmnc_pkg::LevelFull) : '0;
         mmnc_pkg::ModeGrey: return mmnc_pkg::PixelW'(norm_level(d, s));
         mmnc_pkg::ModeRgb:
            return {mmnc_pkg::LevelFull, mmnc_pkg::LevelFull,
                    norm_level(g, s), norm_level(d, s)};
         default: return '0;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      error_count++;
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(12, 48);
   endfunction

   // results are checked before the item accepted at the same edge is predicted
   always @(posedge clock) begin
      logic [mmnc_pkg::PixelW-1:0] want;
      if (reset) begin
         span_lo = mmnc_pkg::SpanMinReset;
         span_hi = mmnc_pkg::SpanMaxReset;
         mode_shadow = mmnc_pkg::ModeReset;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pixel_queue.size() == 0) begin
               report_mismatch($sformatf("pixel %h with no item outstanding", rsp_pixel));
            end else begin
               want = pixel_queue.pop_front();
               if (rsp_pixel !== want)
                  report_mismatch($sformatf("pixel %h, expected %h", rsp_pixel, want));
            end
         end
         if (csr_valid && csr_ready)
            mode_shadow = csr_colormap_mode;
         if (req_valid && req_ready) begin
            if (req_op == mmnc_pkg::OpScan) begin
               if (req_first) begin
                  span_lo = req_sample;
                  span_hi = req_sample;
               end else begin
                  if (req_sample > span_hi) span_hi = req_sample;
                  if (req_sample < span_lo) span_lo = req_sample;
               end
            end else begin
               want = map_pixel(req_sample);
               pixel_queue.push_back(pin_valid ? pin_pixel : want);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (steady_timer == 0) begin
         steady_timer <= $urandom_range(100, 400);
         steady <= ($urandom_range(0, 3) == 0);
      end else begin
         steady_timer <= steady_timer - 1;
      end
      if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!steady && $urandom_range(0, 3) == 0)
            stall_left <= pick_gap();
      end
   end

   task automatic push_item(input logic op, input logic first,
                            input logic signed [mmnc_pkg::SampleW-1:0] sample,
                            input logic pinned, input logic [mmnc_pkg::PixelW-1:0] pixel);
      int unsigned gap;
      req_valid <= 1'b1;
      req_op <= op;
      req_first <= first;
      req_sample <= sample;
      pin_valid <= pinned;
      pin_pixel <= pixel;
      do @(posedge clock); while (!req_ready);
      gap = burst ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_mode(input logic [mmnc_pkg::ModeW-1:0] m);
      wait_idle();
      csr_valid <= 1'b1;
      csr_colormap_mode <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      #10_000_000;
      $display("min_max_normalize_colormap: mismatch");
      $finish;
   end

   initial begin
      int unsigned                         sent;
      int unsigned                         n_scan;
      int unsigned                         n_map;
      int unsigned                         r;
      logic                                first;
      logic signed [mmnc_pkg::SampleW-1:0] base;
      logic signed [mmnc_pkg::SampleW-1:0] lo;
      logic signed [mmnc_pkg::SampleW-1:0] hi;
      logic signed [mmnc_pkg::SampleW-1:0] v;
      logic [mmnc_pkg::SampleW-1:0]        width;

      sent = 0;
      lo = '0;
      hi = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_CFG: write_mode(directed_rows[i].mode);
            ROW_SCAN: push_item(mmnc_pkg::OpScan, directed_rows[i].first,
                                directed_rows[i].sample, 1'b0, '0);
            default: push_item(mmnc_pkg::OpMap, directed_rows[i].first,
                               directed_rows[i].sample, directed_rows[i].pinned,
                               directed_rows[i].pixel);
         endcase
      end

      while (sent < RandomItems) begin
         r = $urandom_range(0, 9);
         if (r < 3)
            write_mode(mode_pool[($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2)]);
         else if (r == 3)
            wait_idle();
         burst = ($urandom_range(0, 4) == 0);

         case ($urandom_range(0, 3))
            0: width = '0;
            1: width = $urandom_range(1, 300);
            2: width = $urandom_range(1, 1 << 20);
            default: width = $urandom;
         endcase
         base = $urandom;

         n_scan = $urandom_range(1, 10);
         for (int unsigned k = 0; k < n_scan; k++) begin
            v = base + $urandom_range(width, 0);
            first = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
            if (k == 0 || first) begin
               lo = v;
               hi = v;
            end else begin
               if (v > hi) hi = v;
               if (v < lo) lo = v;
            end
            push_item(mmnc_pkg::OpScan, first, v, 1'b0, '0);
            sent++;
         end

         n_map = $urandom_range(1, 16);
         for (int unsigned k = 0; k < n_map; k++) begin
            case ($urandom_range(0, 9))
               0: v = lo;
               1: v = hi;
               2: v = lo - $urandom_range(1, 1000);
               3: v = hi + $urandom_range(1, 1000);
               4: v = $urandom;
               5: v = lo + (mmnc_pkg::SampleW'(hi - lo) >> 1) + $urandom_range(0, 1);
               default: v = lo + $urandom_range(mmnc_pkg::SampleW'(hi - lo), 0);
            endcase
            push_item(mmnc_pkg::OpMap, 1'($urandom_range(0, 1)), v, 1'b0, '0);
            sent++;
         end

         // unstructured items: random op, flag and sample
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                         1'b0, '0);
               sent++;
            end
         end
      end

      burst = 1'b0;
      wait_idle();
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0)
         $display("min_max_normalize_colormap: match");
      else
         $display("min_max_normalize_colormap: mismatch");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+sv
sv/mmnc_pkg.sv
sv/mmnc_front.sv
sv/mmnc_queue.sv
sv/mmnc_back.sv
sv/min_max_normalize_colormap.sv
sv/mmnc_checker.sv
tb/sv/tb_min_max_normalize_colormap.sv
